>>> sv/i2cmrt_pkg.sv
`default_nettype none
package i2cmrt_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] RD_BIT   = 8'h01;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_TICK  = 2'd3
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_A,
    PH_ADDR_W,
    PH_ACK_ADDR_W,
    PH_REG,
    PH_ACK_REG,
    PH_DATA,
    PH_ACK_DATA,
    PH_START_B,
    PH_ADDR_R,
    PH_ACK_ADDR_R,
    PH_RECV,
    PH_MACK,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] target_id;
    logic [7:0] reg_index;
    logic [7:0] length;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       error;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [BUF_AW-1:0] raddr;
  } ram_ctl_t;

endpackage
`default_nettype wire

>>> sv/i2cmrt_ram.sv
`default_nettype none
module i2cmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/i2cmrt_seq.sv
`default_nettype none
module i2cmrt_seq
  import i2cmrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire in_t        item,
  input  wire logic [7:0] buf_rdata,
  output      ram_ctl_t   ram_ctl,
  output      out_t       res
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        byte_cnt_r, byte_cnt_nxt;
  logic [BUF_AW-1:0] fill_ptr_r, fill_ptr_nxt;
  logic [BUF_AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [6:0]        tgt_r, tgt_nxt;
  logic [7:0]        reg_r, reg_nxt;
  logic [7:0]        len_r, len_nxt;
  logic              is_read_r, is_read_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              nack_r, nack_nxt;
  logic              rv, dn, last_ack;
  logic [3:0]        bit_inc;
  logic [7:0]        rx_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      step_r     <= '0;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      byte_cnt_r <= '0;
      fill_ptr_r <= '0;
      rd_idx_r   <= '0;
      tgt_r      <= '0;
      reg_r      <= '0;
      len_r      <= '0;
      is_read_r  <= 1'b0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      nack_r     <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      fill_ptr_r <= fill_ptr_nxt;
      rd_idx_r   <= rd_idx_nxt;
      tgt_r      <= tgt_nxt;
      reg_r      <= reg_nxt;
      len_r      <= len_nxt;
      is_read_r  <= is_read_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      nack_r     <= nack_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_cnt_nxt = byte_cnt_r;
    fill_ptr_nxt = fill_ptr_r;
    rd_idx_nxt   = rd_idx_r;
    tgt_nxt      = tgt_r;
    reg_nxt      = reg_r;
    len_nxt      = len_r;
    is_read_nxt  = is_read_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    nack_nxt     = nack_r;
    rv           = 1'b0;
    dn           = 1'b0;
    bit_inc      = bit_cnt_r + 4'd1;
    rx_shift     = {shift_r[6:0], item.sda_in};
    last_ack     = (byte_cnt_r == len_r);

    ram_ctl.we    = 1'b0;
    ram_ctl.waddr = fill_ptr_r;
    ram_ctl.wdata = item.write_byte;
    ram_ctl.raddr = rd_idx_r;

    unique case (item.action) inside
      ACT_LOAD: begin
        if (phase_r == PH_IDLE) begin
          ram_ctl.we   = accept;
          fill_ptr_nxt = (fill_ptr_r == BUF_AW'(BUF_DEPTH - 1)) ? '0 : fill_ptr_r + 1'b1;
        end
      end
      ACT_WRITE, ACT_READ: begin
        if (phase_r == PH_IDLE) begin
          tgt_nxt      = item.target_id;
          reg_nxt      = item.reg_index;
          len_nxt      = item.length;
          is_read_nxt  = (item.action == ACT_READ);
          if (item.action == ACT_WRITE) begin
            fill_ptr_nxt = '0;
          end
          byte_cnt_nxt = '0;
          rd_idx_nxt   = '0;
          nack_nxt     = 1'b0;
          shift_nxt    = '0;
          phase_nxt    = PH_START_A;
          step_nxt     = '0;
          bit_cnt_nxt  = '0;
        end
      end
      ACT_TICK: begin
        unique case (phase_r) inside
          PH_IDLE: ;
          PH_START_A, PH_START_B: begin
            if (step_r == 2'd0) begin
              scl_nxt  = 1'b1;
              sda_nxt  = 1'b1;
              step_nxt = 2'd1;
            end else if (step_r == 2'd1) begin
              sda_nxt  = 1'b0;
              step_nxt = 2'd2;
            end else begin
              scl_nxt     = 1'b0;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
              if (phase_r == PH_START_A) begin
                phase_nxt = PH_ADDR_W;
                shift_nxt = {tgt_r, 1'b0};
              end else begin
                phase_nxt = PH_ADDR_R;
                shift_nxt = {tgt_r, 1'b0} | RD_BIT;
              end
            end
          end
          PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R: begin
            if (step_r == 2'd0) begin
              sda_nxt  = |(shift_r & MSB_MASK);
              scl_nxt  = 1'b1;
              step_nxt = 2'd1;
            end else begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = bit_inc;
              step_nxt    = '0;
              if (bit_inc >= 4'd8) begin
                bit_cnt_nxt = '0;
                unique case (phase_r) inside
                  PH_ADDR_W: phase_nxt = PH_ACK_ADDR_W;
                  PH_REG:    phase_nxt = PH_ACK_REG;
                  PH_DATA:   phase_nxt = PH_ACK_DATA;
                  default:   phase_nxt = PH_ACK_ADDR_R;
                endcase
              end
            end
          end
          PH_ACK_ADDR_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDR_R: begin
            if (step_r == 2'd0) begin
              sda_nxt  = 1'b1;
              step_nxt = 2'd1;
            end else if (step_r == 2'd1) begin
              scl_nxt  = 1'b1;
              step_nxt = 2'd2;
            end else if (step_r == 2'd2) begin
              nack_nxt = item.sda_in;
              step_nxt = 2'd3;
            end else begin
              scl_nxt     = 1'b0;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
              if (nack_r) begin
                phase_nxt = PH_STOP;
              end else if (phase_r == PH_ACK_ADDR_W) begin
                phase_nxt = PH_REG;
                shift_nxt = reg_r;
              end else if (phase_r == PH_ACK_ADDR_R) begin
                if (len_r != 8'd0) begin
                  phase_nxt = PH_RECV;
                  shift_nxt = '0;
                end else begin
                  phase_nxt = PH_STOP;
                end
              end else if (phase_r == PH_ACK_REG && is_read_r) begin
                phase_nxt = PH_START_B;
              end else if (byte_cnt_r < len_r) begin
                phase_nxt    = PH_DATA;
                shift_nxt    = buf_rdata;
                byte_cnt_nxt = byte_cnt_r + 8'd1;
                rd_idx_nxt   = (rd_idx_r == BUF_AW'(BUF_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
          end
          PH_RECV: begin
            sda_nxt = 1'b1;
            if (step_r == 2'd0) begin
              scl_nxt  = 1'b1;
              step_nxt = 2'd1;
            end else begin
              shift_nxt   = rx_shift;
              scl_nxt     = 1'b0;
              bit_cnt_nxt = bit_inc;
              step_nxt    = '0;
              if (bit_inc >= 4'd8) begin
                rv           = 1'b1;
                byte_cnt_nxt = byte_cnt_r + 8'd1;
                phase_nxt    = PH_MACK;
                bit_cnt_nxt  = '0;
              end
            end
          end
          PH_MACK: begin
            sda_nxt = last_ack;
            if (step_r == 2'd0) begin
              scl_nxt  = 1'b0;
              step_nxt = 2'd1;
            end else if (step_r == 2'd1) begin
              scl_nxt  = 1'b1;
              step_nxt = 2'd2;
            end else begin
              scl_nxt     = 1'b0;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
              if (last_ack) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = PH_RECV;
                shift_nxt = '0;
                sda_nxt   = 1'b1;
              end
            end
          end
          PH_STOP: begin
            if (step_r == 2'd0) begin
              sda_nxt  = 1'b0;
              step_nxt = 2'd1;
            end else if (step_r == 2'd1) begin
              scl_nxt  = 1'b1;
              step_nxt = 2'd2;
            end else begin
              sda_nxt     = 1'b1;
              dn          = 1'b1;
              phase_nxt   = PH_IDLE;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.read_byte  = rv ? shift_nxt : 8'd0;
    res.read_valid = rv;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = dn;
    res.error      = dn & nack_r;
  end

endmodule
`default_nettype wire

>>> sv/i2c_master_register_transfer.sv
// channel  | ports                          | moves
// ---------+--------------------------------+---------------------------------
// input    | in_valid, in_ready, in_data    | load, start write/read or tick
// result   | out_valid, out_ready, out_data | line drive, read byte, status
//
// one transaction per clock while the result register is free; each input is handled in the cycle it is accepted
// the write buffer ram is read ahead at the current byte index, so its
// registered read stays hidden behind the bit timing
// rst_n is synchronous: lines released, sequencer idle, buffer contents kept
// a stalled result holds in_ready low until out_ready frees the output register
`default_nettype none
module i2c_master_register_transfer
  import i2cmrt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_ready,
  output      out_t out_data
);

  logic       accept;
  logic       out_valid_r;
  out_t       out_data_r;
  out_t       res;
  ram_ctl_t   ram_ctl;
  logic [7:0] buf_rdata;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cmrt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .buf_rdata (buf_rdata),
    .ram_ctl   (ram_ctl),
    .res       (res)
  );

  i2cmrt_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata),
    .raddr (ram_ctl.raddr),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_i2c_master_register_transfer.sv
`timescale 1ns / 100ps
module tb_i2c_master_register_transfer
  import i2cmrt_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_TOTAL    = 960;
  localparam int SETTLE_CYCLES  = 16;

  typedef enum int {
    DATA_RANDOM,
    DATA_ONES,
    DATA_ZEROS
  } read_data_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  i2c_master_register_transfer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer state as the bus should see it
  phase_t     seq_phase = PH_IDLE;
  logic [2:0] seq_step = '0;
  logic [3:0] seq_bits = '0;
  logic [7:0] seq_shift = '0;
  logic [7:0] seq_bytes = '0;
  logic [7:0] seq_fill = '0;
  logic [6:0] seq_target = '0;
  logic [7:0] seq_reg = '0;
  logic [7:0] seq_len = '0;
  logic       seq_is_read = 1'b0;
  logic       seq_scl = 1'b1;
  logic       seq_sda = 1'b1;
  logic       seq_nack = 1'b0;
  logic [7:0] tx_buffer [256];
  bit         tx_loaded [256];

  out_t pending_line_states [$];

  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         items_sent = 0;
  bit         no_idle = 1'b0;
  int         nack_slot = -1;
  int         acks_answered = 0;
  read_data_t read_mode = DATA_RANDOM;

  task automatic enter_phase(input phase_t next);
    seq_phase = next;
    seq_step = '0;
    seq_bits = '0;
  endtask

  task automatic load_shift(input phase_t next, input logic [7:0] value);
    enter_phase(next);
    seq_shift = value;
  endtask

  task automatic next_write_byte();
    if (seq_bytes < seq_len) begin
      load_shift(PH_DATA, tx_buffer[seq_bytes]);
      seq_bytes = seq_bytes + 8'd1;
    end else begin
      enter_phase(PH_STOP);
    end
  endtask

  task automatic tick_model(input logic sda_smp, output logic [7:0] rx_byte,
                            output logic rx_vld, output logic stop_done);
    logic ack_bit;
    rx_byte = '0;
    rx_vld = 1'b0;
    stop_done = 1'b0;
    case (seq_phase)
      PH_START_A, PH_START_B: begin
        if (seq_step == 3'd0) begin
          seq_scl = 1'b1;
          seq_sda = 1'b1;
          seq_step = 3'd1;
        end else if (seq_step == 3'd1) begin
          seq_sda = 1'b0;
          seq_step = 3'd2;
        end else begin
          seq_scl = 1'b0;
          if (seq_phase == PH_START_A) load_shift(PH_ADDR_W, {seq_target, 1'b0});
          else load_shift(PH_ADDR_R, {seq_target, 1'b1});
        end
      end
      PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R: begin
        if (seq_step == 3'd0) begin
          seq_sda = seq_shift[7];
          seq_scl = 1'b1;
          seq_step = 3'd1;
        end else begin
          seq_scl = 1'b0;
          seq_shift = seq_shift << 1;
          seq_bits = seq_bits + 4'd1;
          seq_step = 3'd0;
          if (seq_bits >= 4'd8) begin
            case (seq_phase)
              PH_ADDR_W: seq_phase = PH_ACK_ADDR_W;
              PH_REG:    seq_phase = PH_ACK_REG;
              PH_DATA:   seq_phase = PH_ACK_DATA;
              default:   seq_phase = PH_ACK_ADDR_R;
            endcase
            seq_bits = '0;
          end
        end
      end
      PH_ACK_ADDR_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDR_R: begin
        if (seq_step == 3'd0) begin
          seq_sda = 1'b1;
          seq_step = 3'd1;
        end else if (seq_step == 3'd1) begin
          seq_scl = 1'b1;
          seq_step = 3'd2;
        end else if (seq_step == 3'd2) begin
          seq_nack = sda_smp;
          seq_step = 3'd3;
        end else begin
          seq_scl = 1'b0;
          if (seq_nack) begin
            enter_phase(PH_STOP);
          end else begin
            case (seq_phase)
              PH_ACK_ADDR_W: load_shift(PH_REG, seq_reg);
              PH_ACK_REG: begin
                if (seq_is_read) enter_phase(PH_START_B);
                else next_write_byte();
              end
              PH_ACK_DATA: next_write_byte();
              default: begin
                if (seq_len > 8'd0) load_shift(PH_RECV, 8'd0);
                else enter_phase(PH_STOP);
              end
            endcase
          end
        end
      end
      PH_RECV: begin
        seq_sda = 1'b1;
        if (seq_step == 3'd0) begin
          seq_scl = 1'b1;
          seq_step = 3'd1;
        end else begin
          seq_shift = {seq_shift[6:0], sda_smp};
          seq_scl = 1'b0;
          seq_bits = seq_bits + 4'd1;
          seq_step = 3'd0;
          if (seq_bits >= 4'd8) begin
            rx_byte = seq_shift;
            rx_vld = 1'b1;
            seq_bytes = seq_bytes + 8'd1;
            enter_phase(PH_MACK);
          end
        end
      end
      PH_MACK: begin
        ack_bit = (seq_bytes == seq_len);
        seq_sda = ack_bit;
        if (seq_step == 3'd0) begin
          seq_scl = 1'b0;
          seq_step = 3'd1;
        end else if (seq_step == 3'd1) begin
          seq_scl = 1'b1;
          seq_step = 3'd2;
        end else begin
          seq_scl = 1'b0;
          if (ack_bit) begin
            enter_phase(PH_STOP);
          end else begin
            load_shift(PH_RECV, 8'd0);
            seq_sda = 1'b1;
          end
        end
      end
      PH_STOP: begin
        if (seq_step == 3'd0) begin
          seq_sda = 1'b0;
          seq_step = 3'd1;
        end else if (seq_step == 3'd1) begin
          seq_scl = 1'b1;
          seq_step = 3'd2;
        end else begin
          seq_sda = 1'b1;
          stop_done = 1'b1;
          enter_phase(PH_IDLE);
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_scl = 1'b1;
        seq_sda = 1'b1;
      end
    endcase
  endtask

  task automatic advance_bus_model(input in_t item);
    out_t       res;
    logic [7:0] rx_byte;
    logic       rx_vld;
    logic       stop_done;
    rx_byte = '0;
    rx_vld = 1'b0;
    stop_done = 1'b0;
    case (item.action)
      ACT_LOAD: begin
        if (seq_phase == PH_IDLE) begin
          tx_buffer[seq_fill] = item.write_byte;
          tx_loaded[seq_fill] = 1'b1;
          seq_fill = seq_fill + 8'd1;
        end
      end
      ACT_WRITE, ACT_READ: begin
        if (seq_phase == PH_IDLE) begin
          seq_target = item.target_id;
          seq_reg = item.reg_index;
          seq_len = item.length;
          seq_is_read = (item.action == ACT_READ);
          if (!seq_is_read) seq_fill = '0;
          seq_bytes = '0;
          seq_nack = 1'b0;
          load_shift(PH_START_A, 8'd0);
        end
      end
      default: begin
        if (seq_phase != PH_IDLE) tick_model(item.sda_in, rx_byte, rx_vld, stop_done);
      end
    endcase
    res.scl_level = seq_scl;
    res.sda_level = seq_sda;
    res.read_byte = rx_byte;
    res.read_valid = rx_vld;
    res.busy_res = (seq_phase != PH_IDLE);
    res.done_res = stop_done;
    res.error = stop_done & seq_nack;
    pending_line_states.push_back(res);
  endtask

  function automatic in_t random_item();
    in_t item;
    item.action = 2'($urandom_range(0, 3));
    item.target_id = 7'($urandom);
    item.reg_index = 8'($urandom);
    item.length = 8'($urandom);
    item.write_byte = 8'($urandom);
    item.sda_in = 1'($urandom_range(0, 1));
    return item;
  endfunction

  task automatic send_item(input in_t item);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    advance_bus_model(item);
  endtask

  task automatic send_load(input logic [7:0] value);
    in_t item;
    item = random_item();
    item.action = ACT_LOAD;
    item.write_byte = value;
    send_item(item);
  endtask

  task automatic send_start(input act_t kind, input logic [6:0] dev,
                            input logic [7:0] regaddr, input logic [7:0] len);
    in_t item;
    int  n;
    // a write may only send buffer entries that were loaded at some point
    if (kind == ACT_WRITE && seq_phase == PH_IDLE) begin
      for (n = 0; n < 256 && tx_loaded[n]; n++) ;
      if (len > n) len = 8'(n);
    end
    item = random_item();
    item.action = kind;
    item.target_id = dev;
    item.reg_index = regaddr;
    item.length = len;
    send_item(item);
  endtask

  task automatic send_tick();
    in_t item;
    item = random_item();
    item.action = ACT_TICK;
    if (seq_phase inside {PH_ACK_ADDR_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDR_R}
        && seq_step == 3'd2) begin
      item.sda_in = (acks_answered == nack_slot);
      acks_answered++;
    end else if (seq_phase == PH_RECV && seq_step == 3'd1) begin
      if (read_mode == DATA_ONES) item.sda_in = 1'b1;
      else if (read_mode == DATA_ZEROS) item.sda_in = 1'b0;
    end
    send_item(item);
  endtask

  task automatic drive_to_idle();
    while (seq_phase != PH_IDLE) send_tick();
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_line_states.size() != 0) @(posedge clk);
  endtask

  task automatic run_transfer(input act_t kind, input logic [6:0] dev,
                              input logic [7:0] regaddr, input logic [7:0] len,
                              input int nack_at, input read_data_t mode, input bit noisy);
    in_t item;
    nack_slot = nack_at;
    acks_answered = 0;
    read_mode = mode;
    send_start(kind, dev, regaddr, len);
    while (seq_phase != PH_IDLE) begin
      if (noisy && $urandom_range(0, 99) < 8) begin
        item = random_item();
        item.action = 2'($urandom_range(0, 2));
        send_item(item);
      end else begin
        send_tick();
      end
    end
  endtask

  task automatic test_idle_ticks();
    in_t item;
    item = random_item();
    item.action = ACT_TICK;
    item.sda_in = 1'b0;
    send_item(item);
    item.sda_in = 1'b1;
    send_item(item);
  endtask

  task automatic test_read_extremes();
    run_transfer(ACT_READ, 7'h00, 8'h00, 8'd2, -1, DATA_ONES, 1'b0);
    run_transfer(ACT_READ, 7'h2A, 8'h81, 8'd1, -1, DATA_ZEROS, 1'b0);
  endtask

  task automatic test_zero_length();
    run_transfer(ACT_WRITE, 7'h12, 8'h34, 8'd0, -1, DATA_RANDOM, 1'b0);
    run_transfer(ACT_READ, 7'h21, 8'h43, 8'd0, -1, DATA_RANDOM, 1'b0);
  endtask

  task automatic test_nack_slots();
    int s;
    for (s = 0; s < 3; s++) begin
      send_load(8'($urandom));
      run_transfer(ACT_WRITE, 7'($urandom), 8'($urandom), 8'd1, s, DATA_RANDOM, 1'b0);
    end
    // nack on the address after the repeated start
    run_transfer(ACT_READ, 7'($urandom), 8'($urandom), 8'd1, 2, DATA_RANDOM, 1'b0);
  endtask

  task automatic test_ignored_while_busy();
    send_load(8'h11);
    nack_slot = -1;
    acks_answered = 0;
    read_mode = DATA_RANDOM;
    send_start(ACT_WRITE, 7'h33, 8'h44, 8'd1);
    repeat (6) send_tick();
    // neither of these may touch the transfer in flight
    send_load(8'hC3);
    send_start(ACT_READ, 7'h55, 8'h10, 8'd9);
    drive_to_idle();
  endtask

  task automatic test_buffer_wrap();
    int i;
    wait_for_drain();
    no_idle = 1'b1;
    // the last load wraps the fill pointer back onto entry 0
    for (i = 0; i < 256; i++) send_load((i == 1) ? 8'hFF : 8'($urandom));
    send_load(8'h00);
    run_transfer(ACT_WRITE, 7'h7F, 8'hFF, 8'd2, -1, DATA_RANDOM, 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int         i;
    int         len;
    int         nack_at;
    bit         is_wr;
    read_data_t mode;
    while (items_sent < ITEMS_TOTAL) begin
      if ($urandom_range(0, 5) == 0) wait_for_drain();
      if ($urandom_range(0, 99) < 70) begin
        drive_to_idle();
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8))
                                          : int'($urandom_range(0, 4));
        nack_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4)) : -1;
        is_wr = 1'($urandom_range(0, 1));
        mode = read_data_t'($urandom_range(0, 2));
        if (is_wr) begin
          for (i = 0; i < len; i++) send_load(8'($urandom));
        end
        run_transfer(is_wr ? ACT_WRITE : ACT_READ, 7'($urandom), 8'($urandom), 8'(len),
                     nack_at, mode, 1'b1);
      end else begin
        case ($urandom_range(0, 2))
          0: send_load(8'($urandom));
          1: begin
            if (seq_phase == PH_IDLE) begin
              nack_slot = int'($urandom_range(0, 3));
              acks_answered = 0;
            end
            len = int'($urandom_range(0, 4));
            send_start($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 7'($urandom),
                       8'($urandom), 8'(len));
          end
          default: send_tick();
        endcase
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_line_states.size() == 0) begin
        flag_mismatch("unrequested transaction", '0, out_data);
      end else begin
        want = pending_line_states.pop_front();
        if (out_data !== want) flag_mismatch("result", want, out_data);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_read_extremes();
    test_zero_length();
    test_nack_slots();
    test_ignored_while_busy();
    test_buffer_wrap();
    test_random();
    in_valid <= 1'b0;
    while (pending_line_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_line_states.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/i2cmrt_pkg.sv
sv/i2cmrt_ram.sv
sv/i2cmrt_seq.sv
sv/i2c_master_register_transfer.sv
dv/tb_i2c_master_register_transfer.sv
